### design/mocs_pkg.sv
// Package for the motor open/close sequencer.
// Holds the phase, mode, position and run-step types, register indexes and reset values.
// No dependencies.
package mocs_pkg;

    localparam int CFG_TICK_W = 24;
    localparam int DUTY_W     = 10;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_IDLE    = 3'd1,
        PH_DELAY   = 3'd2,
        PH_SELECT  = 3'd3,
        PH_UNKNOWN = 3'd4,
        PH_OPEN    = 3'd5,
        PH_CLOSE   = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        MODE_LOW  = 2'd0,
        MODE_HIGH = 2'd1,
        MODE_PWM  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        POS_UNKNOWN = 2'd0,
        POS_OPEN    = 2'd1,
        POS_CLOSED  = 2'd2
    } t_pos;

    typedef enum logic [1:0] {
        RUN_SETUP = 2'd0,
        RUN_DRIVE = 2'd1,
        RUN_STOP  = 2'd2
    } t_run_step;

    typedef enum logic [2:0] {
        CFG_SWITCH_DELAY  = 3'd0,
        CFG_RUN_TIMEOUT   = 3'd1,
        CFG_OPEN_STOP     = 3'd2,
        CFG_CLOSE_STOP    = 3'd3,
        CFG_UNKNOWN_STOP  = 3'd4,
        CFG_DRIVE_DUTY    = 3'd5,
        CFG_UNKNOWN_DUTY  = 3'd6,
        CFG_END_DUTY      = 3'd7
    } t_cfg_idx;

    localparam logic [CFG_TICK_W-1:0] RST_SWITCH_DELAY = 24'd500000;
    localparam logic [CFG_TICK_W-1:0] RST_RUN_TIMEOUT  = 24'd3000000;
    localparam logic [CFG_TICK_W-1:0] RST_OPEN_STOP    = 24'd300000;
    localparam logic [CFG_TICK_W-1:0] RST_CLOSE_STOP   = 24'd10000;
    localparam logic [CFG_TICK_W-1:0] RST_UNKNOWN_STOP = 24'd1000;
    localparam logic [DUTY_W-1:0]     RST_DRIVE_DUTY   = 10'd999;
    localparam logic [DUTY_W-1:0]     RST_UNKNOWN_DUTY = 10'd700;
    localparam logic [DUTY_W-1:0]     RST_END_DUTY     = 10'd300;

endpackage

### design/motor_open_close_sequencer.sv
// Top level of the motor open/close sequencer: tick channel, result channel, APB registers.
// Depends on mocs_pkg.
// Latency: the result of a tick is valid in the cycle after the tick is accepted.
// One tick per clock unless stalled; phase, timer and drive registers update in one pass.
// A new tick is taken while the previous result is being taken in the same cycle.
// Synchronous active-low reset puts the registers at their reset values, the phase at start,
// both channels at high brake and the result channel empty.
module motor_open_close_sequencer
    import mocs_pkg::*;
#(
    parameter int TIMER_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_power_switch_on,
    input  logic                  i_at_open_limit,
    input  logic                  i_at_close_limit,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [1:0]            o_chan_a_mode,
    output logic [1:0]            o_chan_b_mode,
    output logic [DUTY_W-1:0]     o_pwm_compare,
    output logic [1:0]            o_last_position,
    output logic [2:0]            o_phase,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CMP_W = (TIMER_BITS > CFG_TICK_W) ? TIMER_BITS : CFG_TICK_W;

    logic [CFG_TICK_W-1:0] r_switch_delay;
    logic [CFG_TICK_W-1:0] r_run_timeout;
    logic [CFG_TICK_W-1:0] r_open_stop;
    logic [CFG_TICK_W-1:0] r_close_stop;
    logic [CFG_TICK_W-1:0] r_unknown_stop;
    logic [DUTY_W-1:0]     r_drive_duty;
    logic [DUTY_W-1:0]     r_unknown_duty;
    logic [DUTY_W-1:0]     r_end_duty;

    t_phase                r_phase,    n_phase;
    t_run_step             r_run_step, n_run_step;
    logic [TIMER_BITS-1:0] r_elapsed,  n_elapsed;
    t_pos                  r_position, n_position;
    logic [DUTY_W-1:0]     r_compare,  n_compare;
    t_mode                 r_mode_a,   n_mode_a;
    t_mode                 r_mode_b,   n_mode_b;
    logic                  r_out_valid;

    logic                  in_accept;
    logic                  cfg_write;
    t_cfg_idx              cfg_idx;
    logic                  restart;
    logic [TIMER_BITS-1:0] now;
    logic [CMP_W-1:0]      now_ext;
    logic                  run_limit;
    logic [CFG_TICK_W-1:0] run_stop_ticks;
    logic [DUTY_W-1:0]     run_duty;
    t_mode                 run_mode_a;
    t_mode                 run_mode_b;
    t_pos                  run_end_pos;
    logic                  run_ends;
    logic                  stop_done;
    logic                  delay_done;

    assign pready    = 1'b1;
    assign cfg_idx   = t_cfg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_switch_delay <= RST_SWITCH_DELAY;
            r_run_timeout  <= RST_RUN_TIMEOUT;
            r_open_stop    <= RST_OPEN_STOP;
            r_close_stop   <= RST_CLOSE_STOP;
            r_unknown_stop <= RST_UNKNOWN_STOP;
            r_drive_duty   <= RST_DRIVE_DUTY;
            r_unknown_duty <= RST_UNKNOWN_DUTY;
            r_end_duty     <= RST_END_DUTY;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                CFG_SWITCH_DELAY: r_switch_delay <= pwdata[CFG_TICK_W-1:0];
                CFG_RUN_TIMEOUT:  r_run_timeout  <= pwdata[CFG_TICK_W-1:0];
                CFG_OPEN_STOP:    r_open_stop    <= pwdata[CFG_TICK_W-1:0];
                CFG_CLOSE_STOP:   r_close_stop   <= pwdata[CFG_TICK_W-1:0];
                CFG_UNKNOWN_STOP: r_unknown_stop <= pwdata[CFG_TICK_W-1:0];
                CFG_DRIVE_DUTY:   r_drive_duty   <= pwdata[DUTY_W-1:0];
                CFG_UNKNOWN_DUTY: r_unknown_duty <= pwdata[DUTY_W-1:0];
                CFG_END_DUTY:     r_end_duty     <= pwdata[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            CFG_SWITCH_DELAY: prdata = CFG_DATA_W'(r_switch_delay);
            CFG_RUN_TIMEOUT:  prdata = CFG_DATA_W'(r_run_timeout);
            CFG_OPEN_STOP:    prdata = CFG_DATA_W'(r_open_stop);
            CFG_CLOSE_STOP:   prdata = CFG_DATA_W'(r_close_stop);
            CFG_UNKNOWN_STOP: prdata = CFG_DATA_W'(r_unknown_stop);
            CFG_DRIVE_DUTY:   prdata = CFG_DATA_W'(r_drive_duty);
            CFG_UNKNOWN_DUTY: prdata = CFG_DATA_W'(r_unknown_duty);
            CFG_END_DUTY:     prdata = CFG_DATA_W'(r_end_duty);
            default:          prdata = '0;
        endcase
    end

    assign o_stall   = r_out_valid && i_stall;
    assign in_accept = i_valid && !o_stall;

    assign now     = (r_elapsed == {TIMER_BITS{1'b1}}) ? r_elapsed
                                                       : TIMER_BITS'(r_elapsed + 1'b1);
    assign now_ext = CMP_W'(now);

    always_comb begin
        run_limit      = i_at_close_limit;
        run_stop_ticks = r_close_stop;
        run_duty       = r_drive_duty;
        run_mode_a     = MODE_PWM;
        run_mode_b     = MODE_LOW;
        run_end_pos    = POS_CLOSED;
        case (r_phase)
            PH_UNKNOWN: begin
                run_stop_ticks = r_unknown_stop;
                run_duty       = r_unknown_duty;
            end
            PH_OPEN: begin
                run_limit      = i_at_open_limit;
                run_stop_ticks = r_open_stop;
                run_mode_a     = MODE_LOW;
                run_mode_b     = MODE_PWM;
                run_end_pos    = POS_OPEN;
            end
            default: begin
            end
        endcase
    end

    assign delay_done = now_ext >= CMP_W'(r_switch_delay);
    assign run_ends   = run_limit || (now_ext >= CMP_W'(r_run_timeout));
    assign stop_done  = now_ext >= CMP_W'(run_stop_ticks);

    always_comb begin
        n_phase    = r_phase;
        n_run_step = r_run_step;
        restart    = 1'b0;
        unique case (r_phase)
            PH_START: begin
                n_phase    = PH_IDLE;
                n_run_step = RUN_SETUP;
            end
            PH_IDLE: begin
                n_run_step = RUN_SETUP;
                if (i_power_switch_on) begin
                    restart = 1'b1;
                    n_phase = PH_DELAY;
                end else begin
                    n_phase = PH_START;
                end
            end
            PH_DELAY: begin
                if (delay_done) begin
                    n_phase    = PH_SELECT;
                    n_run_step = RUN_SETUP;
                end
            end
            PH_SELECT: begin
                n_run_step = RUN_SETUP;
                if (i_at_open_limit) begin
                    n_phase = (r_position == POS_OPEN) ? PH_CLOSE : PH_UNKNOWN;
                end else if (i_at_close_limit) begin
                    n_phase = (r_position == POS_CLOSED) ? PH_OPEN : PH_UNKNOWN;
                end else begin
                    n_phase = PH_UNKNOWN;
                end
            end
            PH_UNKNOWN, PH_OPEN, PH_CLOSE: begin
                case (r_run_step)
                    RUN_SETUP: begin
                        restart    = 1'b1;
                        n_run_step = RUN_DRIVE;
                    end
                    RUN_DRIVE: begin
                        if (run_ends) begin
                            restart    = 1'b1;
                            n_run_step = RUN_STOP;
                        end
                    end
                    RUN_STOP: begin
                        if (stop_done) begin
                            n_phase    = PH_START;
                            n_run_step = RUN_SETUP;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_phase    = PH_START;
                n_run_step = RUN_SETUP;
            end
        endcase
        n_elapsed = restart ? '0 : now;
    end

    always_comb begin
        n_position = r_position;
        n_compare  = r_compare;
        n_mode_a   = r_mode_a;
        n_mode_b   = r_mode_b;
        unique case (r_phase)
            PH_SELECT: begin
                if (!i_at_open_limit && !i_at_close_limit) begin
                    n_position = POS_UNKNOWN;
                end
            end
            PH_UNKNOWN, PH_OPEN, PH_CLOSE: begin
                case (r_run_step)
                    RUN_SETUP: begin
                        n_compare = run_duty;
                        n_mode_a  = run_mode_a;
                        n_mode_b  = run_mode_b;
                    end
                    RUN_DRIVE: begin
                        if (run_ends) begin
                            n_compare = r_end_duty;
                        end
                    end
                    RUN_STOP: begin
                        if (stop_done) begin
                            n_mode_a   = MODE_HIGH;
                            n_mode_b   = MODE_HIGH;
                            n_position = run_end_pos;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_run_step  <= RUN_SETUP;
            r_elapsed   <= '0;
            r_position  <= POS_UNKNOWN;
            r_compare   <= '0;
            r_mode_a    <= MODE_HIGH;
            r_mode_b    <= MODE_HIGH;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_phase     <= n_phase;
                r_run_step  <= n_run_step;
                r_elapsed   <= n_elapsed;
                r_position  <= n_position;
                r_compare   <= n_compare;
                r_mode_a    <= n_mode_a;
                r_mode_b    <= n_mode_b;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_chan_a_mode   = r_mode_a;
    assign o_chan_b_mode   = r_mode_b;
    assign o_pwm_compare   = r_compare;
    assign o_last_position = r_position;
    assign o_phase         = r_phase;

endmodule

### design/mocs_checker.sv
// Port-level checker for the motor open/close sequencer, bound to the top level.
// Depends on mocs_pkg and on the port names of motor_open_close_sequencer.
module mocs_checker
    import mocs_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic                  i_power_switch_on,
    input logic                  i_at_open_limit,
    input logic                  i_at_close_limit,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [1:0]            o_chan_a_mode,
    input logic [1:0]            o_chan_b_mode,
    input logic [DUTY_W-1:0]     o_pwm_compare,
    input logic [1:0]            o_last_position,
    input logic [2:0]            o_phase
);

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_valid)
        else $error("An accepted transaction produced no result.");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_phase) && $stable(o_pwm_compare)
                                  && $stable(o_chan_a_mode) && $stable(o_chan_b_mode)))
        else $error("A stalled result changed or was dropped.");

    a_start_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && o_phase == PH_START) |=> (o_phase == PH_IDLE))
        else $error("The start phase did not move to idle.");

    a_idle_no_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && o_phase == PH_IDLE && !i_power_switch_on)
        |=> (o_phase == PH_START))
        else $error("Idle without a press did not return to start.");

    a_brake_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (o_phase == PH_UNKNOWN || o_phase == PH_OPEN
                                 || o_phase == PH_CLOSE))
        ##1 (o_phase == PH_START) |-> (o_chan_a_mode == MODE_HIGH
                                       && o_chan_b_mode == MODE_HIGH))
        else $error("A run ended without braking both channels.");

endmodule

bind motor_open_close_sequencer mocs_checker u_mocs_checker (.*);

### tb/motor_open_close_checker.sv
// Checker for the motor open/close sequencer: watches the tick, status and register ports,
// predicts each status transaction and compares it field by field.
// Depends on mocs_pkg.
module motor_open_close_checker
    import mocs_pkg::*;
#(
    parameter int TIMER_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_tick_valid,
    input  logic                  i_tick_stall,
    input  logic                  i_power_switch_on,
    input  logic                  i_at_open_limit,
    input  logic                  i_at_close_limit,
    input  logic                  i_status_valid,
    input  logic                  i_status_stall,
    input  logic [1:0]            i_chan_a_mode,
    input  logic [1:0]            i_chan_b_mode,
    input  logic [DUTY_W-1:0]     i_pwm_compare,
    input  logic [1:0]            i_last_position,
    input  logic [2:0]            i_phase,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [CFG_DATA_W-1:0] i_pwdata,
    output int                    o_fail_count,
    output int                    o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_mode               chan_a;
        t_mode               chan_b;
        logic [DUTY_W-1:0]   compare;
        t_pos                position;
        t_phase              phase;
    } t_drive_status;

    t_drive_status           drive_status_q[$];
    logic [CFG_TICK_W-1:0]   cfg_reg [8];
    t_phase                  phase_q;
    t_run_step               run_step_q;
    logic [TIMER_BITS-1:0]   elapsed_q;
    t_pos                    position_q;
    logic [DUTY_W-1:0]       compare_q;
    t_mode                   mode_a_q;
    t_mode                   mode_b_q;

    initial begin
        o_fail_count = 0;
        o_pending_count = 0;
    end

    function automatic void enter_phase(input t_phase next);
        phase_q = next;
        run_step_q = RUN_SETUP;
    endfunction

    function automatic logic run_motion(input logic [TIMER_BITS-1:0] now, input logic limit,
                                        input logic [DUTY_W-1:0] duty, input t_mode mode_a,
                                        input t_mode mode_b, input logic [CFG_TICK_W-1:0] stop_ticks,
                                        input t_pos reached);
        logic restart;
        restart = 1'b0;
        case (run_step_q)
            RUN_SETUP: begin
                restart = 1'b1;
                compare_q = duty;
                mode_a_q = mode_a;
                mode_b_q = mode_b;
                run_step_q = RUN_DRIVE;
            end
            RUN_DRIVE: begin
                if (limit || now >= cfg_reg[CFG_RUN_TIMEOUT]) begin
                    restart = 1'b1;
                    compare_q = cfg_reg[CFG_END_DUTY][DUTY_W-1:0];
                    run_step_q = RUN_STOP;
                end
            end
            RUN_STOP: begin
                if (now >= stop_ticks) begin
                    mode_a_q = MODE_HIGH;
                    mode_b_q = MODE_HIGH;
                    position_q = reached;
                    enter_phase(PH_START);
                end
            end
            default: ;
        endcase
        return restart;
    endfunction

    function automatic t_drive_status next_drive_status(input logic power, input logic open_lim,
                                                        input logic close_lim);
        logic [TIMER_BITS-1:0] now;
        logic                  restart;
        t_drive_status         status;
        restart = 1'b0;
        now = elapsed_q;
        if (now != '1) begin
            now = now + 1'b1;
        end
        case (phase_q)
            PH_START: enter_phase(PH_IDLE);
            PH_IDLE: begin
                if (power) begin
                    restart = 1'b1;
                    enter_phase(PH_DELAY);
                end else begin
                    enter_phase(PH_START);
                end
            end
            PH_DELAY: begin
                if (now >= cfg_reg[CFG_SWITCH_DELAY]) begin
                    enter_phase(PH_SELECT);
                end
            end
            PH_SELECT: begin
                if (open_lim) begin
                    if (position_q == POS_OPEN) begin
                        enter_phase(PH_CLOSE);
                    end else begin
                        enter_phase(PH_UNKNOWN);
                    end
                end else if (close_lim) begin
                    if (position_q == POS_CLOSED) begin
                        enter_phase(PH_OPEN);
                    end else begin
                        enter_phase(PH_UNKNOWN);
                    end
                end else begin
                    position_q = POS_UNKNOWN;
                    enter_phase(PH_UNKNOWN);
                end
            end
            PH_UNKNOWN: begin
                restart = run_motion(now, close_lim, cfg_reg[CFG_UNKNOWN_DUTY][DUTY_W-1:0],
                                     MODE_PWM, MODE_LOW, cfg_reg[CFG_UNKNOWN_STOP], POS_CLOSED);
            end
            PH_OPEN: begin
                restart = run_motion(now, open_lim, cfg_reg[CFG_DRIVE_DUTY][DUTY_W-1:0],
                                     MODE_LOW, MODE_PWM, cfg_reg[CFG_OPEN_STOP], POS_OPEN);
            end
            PH_CLOSE: begin
                restart = run_motion(now, close_lim, cfg_reg[CFG_DRIVE_DUTY][DUTY_W-1:0],
                                     MODE_PWM, MODE_LOW, cfg_reg[CFG_CLOSE_STOP], POS_CLOSED);
            end
            default: enter_phase(PH_START);
        endcase
        elapsed_q = restart ? '0 : now;
        status.chan_a = mode_a_q;
        status.chan_b = mode_b_q;
        status.compare = compare_q;
        status.position = position_q;
        status.phase = phase_q;
        return status;
    endfunction

    function automatic void reset_sequencer();
        cfg_reg[CFG_SWITCH_DELAY] = RST_SWITCH_DELAY;
        cfg_reg[CFG_RUN_TIMEOUT]  = RST_RUN_TIMEOUT;
        cfg_reg[CFG_OPEN_STOP]    = RST_OPEN_STOP;
        cfg_reg[CFG_CLOSE_STOP]   = RST_CLOSE_STOP;
        cfg_reg[CFG_UNKNOWN_STOP] = RST_UNKNOWN_STOP;
        cfg_reg[CFG_DRIVE_DUTY]   = CFG_TICK_W'(RST_DRIVE_DUTY);
        cfg_reg[CFG_UNKNOWN_DUTY] = CFG_TICK_W'(RST_UNKNOWN_DUTY);
        cfg_reg[CFG_END_DUTY]     = CFG_TICK_W'(RST_END_DUTY);
        phase_q = PH_START;
        run_step_q = RUN_SETUP;
        elapsed_q = '0;
        position_q = POS_UNKNOWN;
        compare_q = '0;
        mode_a_q = MODE_HIGH;
        mode_b_q = MODE_HIGH;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_fail_count = o_fail_count + 1;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_drive_status want;
        if (!i_rst_n) begin
            reset_sequencer();
            drive_status_q.delete();
        end else begin
            if (i_status_valid && !i_status_stall) begin
                if (drive_status_q.size() == 0) begin
                    $error("status transaction with no expected status waiting");
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = drive_status_q.pop_front();
                    check_field("chan_a_mode", 32'(want.chan_a), 32'(i_chan_a_mode));
                    check_field("chan_b_mode", 32'(want.chan_b), 32'(i_chan_b_mode));
                    check_field("pwm_compare", 32'(want.compare), 32'(i_pwm_compare));
                    check_field("last_position", 32'(want.position), 32'(i_last_position));
                    check_field("phase", 32'(want.phase), 32'(i_phase));
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[4:2] >= CFG_DRIVE_DUTY) begin
                    cfg_reg[i_paddr[4:2]] = {{(CFG_TICK_W-DUTY_W){1'b0}}, i_pwdata[DUTY_W-1:0]};
                end else begin
                    cfg_reg[i_paddr[4:2]] = i_pwdata[CFG_TICK_W-1:0];
                end
            end
            if (i_tick_valid && !i_tick_stall) begin
                drive_status_q.push_back(next_drive_status(i_power_switch_on, i_at_open_limit,
                                                           i_at_close_limit));
            end
        end
        o_pending_count <= drive_status_q.size();
    end

endmodule

### tb/tb.sv
// Top of the motor open/close sequencer testbench: clock, reset, tick stimulus,
// register programming and status back-pressure around the block and its checker.
// Depends on mocs_pkg, motor_open_close_sequencer and motor_open_close_checker.
module tb;
    import mocs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIMER_BITS = 24;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam logic [31:0] TICK_MAX = 32'hFF_FFFF;
    localparam logic [31:0] DUTY_MAX = 32'h3FF;

    typedef enum int {DOOR_CLOSED, DOOR_OPEN, DOOR_MOVING, DOOR_NOISE} t_door_scenario;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_power_switch_on;
    logic                  i_at_open_limit;
    logic                  i_at_close_limit;
    logic                  o_valid;
    logic                  i_stall;
    logic [1:0]            o_chan_a_mode;
    logic [1:0]            o_chan_b_mode;
    logic [DUTY_W-1:0]     o_pwm_compare;
    logic [1:0]            o_last_position;
    logic [2:0]            o_phase;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int             fail_count;
    int             pending_count;
    int             cycle_count = 0;
    int             hold_requests = 0;
    int             burst_left = 0;
    int             scenario_left = 0;
    t_door_scenario scenario = DOOR_NOISE;

    motor_open_close_sequencer #(.TIMER_BITS(TIMER_BITS)) DUT (.*);

    motor_open_close_checker #(.TIMER_BITS(TIMER_BITS)) status_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_tick_valid      (i_valid),
        .i_tick_stall      (o_stall),
        .i_power_switch_on (i_power_switch_on),
        .i_at_open_limit   (i_at_open_limit),
        .i_at_close_limit  (i_at_close_limit),
        .i_status_valid    (o_valid),
        .i_status_stall    (i_stall),
        .i_chan_a_mode     (o_chan_a_mode),
        .i_chan_b_mode     (o_chan_b_mode),
        .i_pwm_compare     (o_pwm_compare),
        .i_last_position   (o_last_position),
        .i_phase           (o_phase),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_pready          (pready),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .o_fail_count      (fail_count),
        .o_pending_count   (pending_count)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver back-pressure: random stretches of stall patterns, plus a long hold on request.
    int hold_left = 0;
    int holds_served = 0;
    int pattern_left = 0;
    int pattern_kind = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD_CYCLES;
            i_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            if (pattern_left == 0) begin
                pattern_kind = $urandom_range(0, 3);
                pattern_left = $urandom_range(1, 32);
            end
            pattern_left = pattern_left - 1;
            case (pattern_kind)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 1) == 1);
                2: i_stall <= 1'b1;
                default: i_stall <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    task automatic send_tick(input logic power, input logic open_lim, input logic close_lim);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left = burst_left - 1;
        i_valid <= 1'b1;
        i_power_switch_on <= power;
        i_at_open_limit <= open_lim;
        i_at_close_limit <= close_lim;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_random_tick();
        logic power;
        logic open_lim;
        logic close_lim;
        if (scenario_left == 0) begin
            scenario = t_door_scenario'($urandom_range(0, 3));
            scenario_left = $urandom_range(10, 60);
        end
        scenario_left = scenario_left - 1;
        power = ($urandom_range(0, 9) < 7);
        case (scenario)
            DOOR_CLOSED: begin
                open_lim = ($urandom_range(0, 19) == 0);
                close_lim = ($urandom_range(0, 9) != 0);
            end
            DOOR_OPEN: begin
                open_lim = ($urandom_range(0, 9) != 0);
                close_lim = ($urandom_range(0, 19) == 0);
            end
            DOOR_MOVING: begin
                open_lim = ($urandom_range(0, 9) == 0);
                close_lim = ($urandom_range(0, 9) == 0);
            end
            default: begin
                open_lim = ($urandom_range(0, 1) == 1);
                close_lim = ($urandom_range(0, 1) == 1);
            end
        endcase
        send_tick(power, open_lim, close_lim);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_cfg_idx idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_config(input logic [31:0] delay, input logic [31:0] timeout,
                                  input logic [31:0] open_stop, input logic [31:0] close_stop,
                                  input logic [31:0] unknown_stop, input logic [31:0] drive_duty,
                                  input logic [31:0] unknown_duty, input logic [31:0] end_duty);
        apb_write(CFG_SWITCH_DELAY, delay);
        apb_write(CFG_RUN_TIMEOUT, timeout);
        apb_write(CFG_OPEN_STOP, open_stop);
        apb_write(CFG_CLOSE_STOP, close_stop);
        apb_write(CFG_UNKNOWN_STOP, unknown_stop);
        apb_write(CFG_DRIVE_DUTY, drive_duty);
        apb_write(CFG_UNKNOWN_DUTY, unknown_duty);
        apb_write(CFG_END_DUTY, end_duty);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_power_switch_on = 1'b0;
        i_at_open_limit = 1'b0;
        i_at_close_limit = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: idle without a press falls back to start, a press parks in the delay.
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1);
        wait_drained();

        // Short timings walk an unknown run, an open run and a close run with both limits set.
        program_config(0, 1, 0, 0, 0, DUTY_MAX, 0, 1000);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        wait_drained();

        // Maximum timings hold the block in whatever wait it reaches, then zero timings release it.
        program_config(TICK_MAX, TICK_MAX, TICK_MAX, TICK_MAX, TICK_MAX, 0, DUTY_MAX, DUTY_MAX);
        repeat (24) send_tick(1'b1, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
        wait_drained();
        program_config(0, 0, 0, 0, 0, 1000, 1000, 0);
        repeat (24) send_random_tick();
        wait_drained();

        for (int setting = 0; setting < 6; setting++) begin
            program_config($urandom_range(0, 12), $urandom_range(0, 40), $urandom_range(0, 15),
                           $urandom_range(0, 15), $urandom_range(0, 15),
                           $urandom_range(0, 1023), $urandom_range(0, 1023),
                           $urandom_range(0, 1023));
            if (setting == 2) begin
                hold_requests <= hold_requests + 1;
                burst_left = 80;
            end
            repeat (130) send_random_tick();
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### sim.f
design/mocs_pkg.sv
design/motor_open_close_sequencer.sv
design/mocs_checker.sv
tb/motor_open_close_checker.sv
tb/tb.sv
